// ===== hw/rtl/mail_header_utf8_scanner_unit_macros.svh =====
// Assertion macros for the mail header UTF-8 scanner.
`ifndef MAIL_HEADER_UTF8_SCANNER_UNIT_MACROS_SVH
`define MAIL_HEADER_UTF8_SCANNER_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define MHU8S_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mail header scanner: assertion failed");
// Next-cycle implication, disabled while reset is high.
`define MHU8S_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mail header scanner: assertion failed");
`else
`define MHU8S_ASSERT_NOW(label, clk, rst, ante, cons)
`define MHU8S_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/mhu8s_pkg.sv =====
// Package with commands, characters, scanner states and keyword tables.
package mhu8s_pkg;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_ADDR   = 2'd1;
   localparam logic [1:0] CMD_HEADER = 2'd2;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [3:0] RECV_LAST = 4'd8;
   localparam logic [3:0] WITH_LAST = 4'd5;
   localparam logic [3:0] ARG_LAST  = 4'd3;

   typedef enum logic [2:0] {
      SCAN_FIELD_START = 3'd0,
      SCAN_RECV        = 3'd1,
      SCAN_SKIP_LINE   = 3'd2,
      SCAN_WITH        = 3'd3,
      SCAN_ARG         = 3'd4,
      SCAN_AFTER_ARG   = 3'd5,
      SCAN_FOLD        = 3'd6
   } scan_state_type;

   // Upper-case letters of "RECEIVED:"; lower case is bit 5 set on letters.
   function automatic logic recv_match(input logic [3:0] pos, input logic [7:0] ch);
      logic [7:0] up;
      logic       letter;
      begin
         letter = 1'b1;
         case (pos)
            4'd0:    up = "R";
            4'd1:    up = "E";
            4'd2:    up = "C";
            4'd3:    up = "E";
            4'd4:    up = "I";
            4'd5:    up = "V";
            4'd6:    up = "E";
            4'd7:    up = "D";
            default: begin
               up = ":";
               letter = 1'b0;
            end
         endcase
         recv_match = (ch == up) || (letter && (ch == (up | 8'h20)));
      end
   endfunction

   function automatic logic with_match(input logic [3:0] pos, input logic [7:0] ch);
      logic [7:0] up;
      logic       letter;
      begin
         letter = 1'b1;
         case (pos)
            4'd1:    up = "W";
            4'd2:    up = "I";
            4'd3:    up = "T";
            4'd4:    up = "H";
            default: begin
               up = CHAR_SPACE;
               letter = 1'b0;
            end
         endcase
         with_match = (ch == up) || (letter && (ch == (up | 8'h20)));
      end
   endfunction

   function automatic logic arg_match(input logic [3:0] pos, input logic [7:0] ch);
      logic [7:0] up;
      logic       letter;
      begin
         letter = 1'b1;
         case (pos)
            4'd0:    up = "U";
            4'd1:    up = "T";
            4'd2:    up = "F";
            default: begin
               up = "8";
               letter = 1'b0;
            end
         endcase
         arg_match = (ch == up) || (letter && (ch == (up | 8'h20)));
      end
   endfunction

endpackage

// ===== hw/rtl/mail_header_utf8_scanner_unit.sv =====
// A request is held in the input register, and its result appears from the result register.
// Throughput: one byte per cycle while the result is not stalled; the scanner state update is combinational.
// A stalled result holds the result stage, and the input register fills behind it.
// Reset is synchronous and active high: it clears both stages and all scanner state.
// The result fields show the flags after the most recent processed byte.
`include "mail_header_utf8_scanner_unit_macros.svh"

module mail_header_utf8_scanner_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_utf8_found,
   output logic       rsp_scan_done
);
   import mhu8s_pkg::*;

   logic           in_valid_ff;
   logic [1:0]     cmd_ff;
   logic [7:0]     byte_ff;
   logic           rsp_valid_ff;
   scan_state_type state_ff, state_in;
   logic [3:0]     pos_ff, pos_in;
   logic           utf8_ff, utf8_in;
   logic           done_ff, done_in;
   logic           advance;
   logic           update;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign update    = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= SCAN_FIELD_START;
         pos_ff       <= 4'd0;
         utf8_ff      <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (update) begin
            state_ff <= state_in;
            pos_ff   <= pos_in;
            utf8_ff  <= utf8_in;
            done_ff  <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         cmd_ff  <= req_cmd;
         byte_ff <= req_data_byte;
      end
   end

   // Next scanner state for the byte held in the input register.
   always_comb begin
      logic [7:0]     ch;
      scan_state_type st;
      logic [3:0]     mp;
      logic           fin;
      state_in = state_ff;
      pos_in   = pos_ff;
      utf8_in  = utf8_ff;
      done_in  = done_ff;
      ch  = (byte_ff == CHAR_TAB) ? CHAR_SPACE : byte_ff;
      st  = state_ff;
      mp  = pos_ff;
      fin = 1'b0;
      unique case (cmd_ff)
         CMD_CLEAR: begin
            state_in = SCAN_FIELD_START;
            pos_in   = 4'd0;
            utf8_in  = 1'b0;
            done_in  = 1'b0;
         end
         CMD_ADDR: begin
            if (byte_ff[7]) begin
               utf8_in = 1'b1;
               done_in = 1'b1;
            end
         end
         CMD_HEADER: begin
            if (!done_ff && (byte_ff != CHAR_CR)) begin
               // A folded line continues the Received field only when it opens with a space or tab.
               if (st == SCAN_FOLD) begin
                  if (ch == CHAR_SPACE) begin
                     state_in = SCAN_WITH;
                     pos_in   = 4'd1;
                     fin      = 1'b1;
                  end else begin
                     st = SCAN_FIELD_START;
                  end
               end
               if (!fin && (st == SCAN_FIELD_START)) begin
                  if (ch == CHAR_LF) begin
                     state_in = SCAN_FIELD_START;
                     done_in  = 1'b1;
                     fin      = 1'b1;
                  end else begin
                     st = SCAN_RECV;
                     mp = 4'd0;
                  end
               end
               if (!fin) begin
                  unique case (st)
                     SCAN_RECV: begin
                        if (mp > RECV_LAST) begin
                           mp = 4'd0;
                        end
                        if (!recv_match(mp, ch)) begin
                           state_in = SCAN_SKIP_LINE;
                           pos_in   = mp;
                        end else if (mp == RECV_LAST) begin
                           state_in = SCAN_WITH;
                           pos_in   = 4'd0;
                        end else begin
                           state_in = SCAN_RECV;
                           pos_in   = mp + 4'd1;
                        end
                     end
                     SCAN_SKIP_LINE: begin
                        state_in = (ch == CHAR_LF) ? SCAN_FIELD_START : SCAN_SKIP_LINE;
                     end
                     SCAN_WITH: begin
                        if (ch == CHAR_LF) begin
                           state_in = SCAN_FOLD;
                        end else begin
                           if (mp > WITH_LAST) begin
                              mp = 4'd0;
                           end
                           if (!with_match(mp, ch)) begin
                              pos_in = 4'd0;
                           end else if (mp == WITH_LAST) begin
                              state_in = SCAN_ARG;
                              pos_in   = 4'd0;
                           end else begin
                              pos_in = mp + 4'd1;
                           end
                        end
                     end
                     SCAN_ARG: begin
                        if (mp > ARG_LAST) begin
                           mp = 4'd0;
                        end
                        pos_in = mp;
                        // Leading spaces before the argument are skipped.
                        if (!((mp == 4'd0) && (ch == CHAR_SPACE))) begin
                           if (!arg_match(mp, ch)) begin
                              state_in = SCAN_AFTER_ARG;
                           end else if (mp == ARG_LAST) begin
                              utf8_in  = 1'b1;
                              state_in = SCAN_AFTER_ARG;
                              pos_in   = mp + 4'd1;
                           end else begin
                              pos_in = mp + 4'd1;
                           end
                        end
                     end
                     default: begin
                        // After the argument, the next byte is consumed unmatched.
                        if (ch == CHAR_LF) begin
                           done_in = 1'b1;
                        end else begin
                           state_in = SCAN_RECV;
                           pos_in   = 4'd0;
                        end
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid      = rsp_valid_ff;
      rsp_utf8_found = utf8_ff;
      rsp_scan_done  = done_ff;
   end

   `MHU8S_ASSERT_NEXT(a_done_sticky, clock, reset, done_ff && !(update && (cmd_ff == CMD_CLEAR)), done_ff)
   `MHU8S_ASSERT_NEXT(a_utf8_sticky, clock, reset, utf8_ff && !(update && (cmd_ff == CMD_CLEAR)), utf8_ff)
   `MHU8S_ASSERT_NEXT(a_header_ignored, clock, reset, update && done_ff && (cmd_ff == CMD_HEADER), $stable(state_ff) && $stable(pos_ff))
   `MHU8S_ASSERT_NEXT(a_input_holds, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(cmd_ff) && $stable(byte_ff))
   `MHU8S_ASSERT_NOW(a_stall_source, clock, reset, req_stall, in_valid_ff && rsp_valid_ff)

endmodule
